@@ rtl/core/deq_pkg.sv @@
`timescale 1ns / 1ps

package deq_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_LIST       = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_LIST = 1'b1
    } state_t;

    // what a cell takes in on the next edge
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_FROM_LEFT  = 2'd1,
        CELL_FROM_RIGHT = 2'd2,
        CELL_LOAD       = 2'd3
    } cell_op_t;

endpackage

@@ rtl/core/double_ended_queue.sv @@
`timescale 1ns / 1ps

// Bounded deque of DEPTH signed 32-bit values, held in a row of cells with the
// front element always in cell 0. Each input item is one action: push front,
// push back, pop front, pop back or list. Push and pop each give one result
// item (popped value, or element 0 with a status of ok, empty or full).
// A list gives one result per stored element, front to back, tlast on the
// final one; the chain rotates by one cell per emitted element, and no new
// item is taken until the final element is emitted (output stalls delay it).
// An empty list gives a single empty-status result. Action codes 5..7
// are consumed with no result. One output register sits on the result side;
// a new item is taken in the same cycle the pending result is taken.
module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [2:0] action, [34:3] value, rest zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] element
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast
);

    localparam int W  = deq_pkg::DATA_W;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    deq_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic             m_valid_reg, m_valid_next;
    logic [W-1:0]     m_data_reg, m_data_next;
    deq_pkg::status_t m_status_reg, m_status_next;
    logic             m_last_reg, m_last_next;

    logic [W-1:0]      cell_data [DEPTH];
    logic [W-1:0]      left_in   [DEPTH];
    logic [W-1:0]      right_in  [DEPTH];
    deq_pkg::cell_op_t cell_op   [DEPTH];

    deq_pkg::action_t action;
    logic [W-1:0]     value;
    logic             in_fire;
    logic             out_free;
    logic             full;
    logic             empty;
    logic [IW-1:0]    back_idx;
    logic [W-1:0]     back_data;
    logic [W-1:0]     load_data;
    logic             do_push_front;
    logic             do_push_back;
    logic             do_pop_front;
    logic             do_list_step;

    assign action    = deq_pkg::action_t'(s_axis_tdata[2:0]);
    assign value     = s_axis_tdata[34:3];
    assign out_free  = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == deq_pkg::ST_IDLE) && out_free;
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign back_idx  = IW'(count_reg - CW'(1));
    assign back_data = cell_data[back_idx];
    // list rotation wraps the front element to the back slot
    assign load_data = do_list_step ? cell_data[0] : value;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        do_push_front = 1'b0;
        do_push_back  = 1'b0;
        do_pop_front  = 1'b0;
        do_list_step  = 1'b0;

        case (state_reg)
            deq_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (action)
                        deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_BACK:
                        begin
                            m_valid_next = 1'b1;
                            m_data_next  = '0;
                            m_last_next  = 1'b1;
                            if (full)
                            begin
                                m_status_next = deq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                m_status_next = deq_pkg::STAT_OK;
                                count_next    = count_reg + CW'(1);
                                do_push_front = (action == deq_pkg::ACT_PUSH_FRONT);
                                do_push_back  = (action == deq_pkg::ACT_PUSH_BACK);
                            end
                        end
                        deq_pkg::ACT_POP_FRONT, deq_pkg::ACT_POP_BACK:
                        begin
                            m_valid_next = 1'b1;
                            m_last_next  = 1'b1;
                            if (empty)
                            begin
                                m_data_next   = '0;
                                m_status_next = deq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                m_status_next = deq_pkg::STAT_OK;
                                count_next    = count_reg - CW'(1);
                                if (action == deq_pkg::ACT_POP_FRONT)
                                begin
                                    m_data_next  = cell_data[0];
                                    do_pop_front = 1'b1;
                                end
                                else
                                begin
                                    m_data_next = back_data;
                                end
                            end
                        end
                        deq_pkg::ACT_LIST:
                        begin
                            if (empty)
                            begin
                                m_valid_next  = 1'b1;
                                m_data_next   = '0;
                                m_status_next = deq_pkg::STAT_EMPTY;
                                m_last_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = deq_pkg::ST_LIST;
                                idx_next   = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            deq_pkg::ST_LIST:
            begin
                if (out_free)
                begin
                    do_list_step  = 1'b1;
                    m_valid_next  = 1'b1;
                    m_data_next   = cell_data[0];
                    m_status_next = deq_pkg::STAT_OK;
                    m_last_next   = (idx_reg + CW'(1) == count_reg);
                    idx_next      = idx_reg + CW'(1);
                    if (idx_reg + CW'(1) == count_reg)
                    begin
                        state_next = deq_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = deq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= deq_pkg::ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            if (i == 0)
            begin : g_left_head
                assign left_in[i] = value;
            end
            else
            begin : g_left_chain
                assign left_in[i] = cell_data[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_right_tail
                assign right_in[i] = '0;
            end
            else
            begin : g_right_chain
                assign right_in[i] = cell_data[i+1];
            end

            always_comb
            begin
                cell_op[i] = deq_pkg::CELL_HOLD;
                if (do_push_front)
                begin
                    cell_op[i] = deq_pkg::CELL_FROM_LEFT;
                end
                else if (do_pop_front)
                begin
                    cell_op[i] = deq_pkg::CELL_FROM_RIGHT;
                end
                else if (do_push_back && (count_reg == CW'(i)))
                begin
                    cell_op[i] = deq_pkg::CELL_LOAD;
                end
                else if (do_list_step)
                begin
                    if (CW'(i + 1) < count_reg)
                    begin
                        cell_op[i] = deq_pkg::CELL_FROM_RIGHT;
                    end
                    else if (CW'(i + 1) == count_reg)
                    begin
                        cell_op[i] = deq_pkg::CELL_LOAD;
                    end
                end
            end

            deq_cell #(
                .W (W)
            ) u_cell (
                .clk        (clk),
                .op         (cell_op[i]),
                .left_data  (left_in[i]),
                .right_data (right_in[i]),
                .load_data  (load_data),
                .data       (cell_data[i])
            );
        end
    endgenerate

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tlast  = m_last_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count above depth");

    a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == deq_pkg::ST_LIST) |-> (count_reg != '0) && (idx_reg < count_reg))
        else $error("list walk past stored elements");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !full && (action == deq_pkg::ACT_PUSH_FRONT ||
                              action == deq_pkg::ACT_PUSH_BACK))
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("push did not grow the queue");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_status_reg == deq_pkg::STAT_FULL) |-> full)
        else $error("full status while queue not full");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_status_reg != deq_pkg::STAT_OK)
        |-> (m_data_reg == '0) && m_last_reg)
        else $error("error result carries data or is not last");
`endif

endmodule

@@ rtl/core/deq_cell.sv @@
`timescale 1ns / 1ps

module deq_cell #(
    parameter int W = 32
) (
    input  logic             clk,
    input  deq_pkg::cell_op_t op,
    input  logic [W-1:0]     left_data,
    input  logic [W-1:0]     right_data,
    input  logic [W-1:0]     load_data,
    output logic [W-1:0]     data
);

    logic [W-1:0] data_reg;
    logic [W-1:0] data_next;

    always_comb
    begin
        case (op)
            deq_pkg::CELL_FROM_LEFT:  data_next = left_data;
            deq_pkg::CELL_FROM_RIGHT: data_next = right_data;
            deq_pkg::CELL_LOAD:       data_next = load_data;
            default:                  data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ tb/tb_double_ended_queue.sv @@
`timescale 1ns / 1ps

module tb_double_ended_queue;

    localparam int DEPTH = 16;

    typedef struct packed {
        logic [31:0]      element;
        deq_pkg::status_t status;
        logic             last;
    } deq_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // deque mirror
    logic [31:0] ring [DEPTH];
    int          front_idx = 0;
    int          fill_cnt = 0;
    deq_result_t pending_results [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int mismatches = 0;
    int n_items = 0;
    int n_results = 0;
    int n_full = 0;
    int n_empty = 0;
    int n_lists = 0;

    double_ended_queue #(.DEPTH(DEPTH)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [2:0] action, [34:3] value, rest zero
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [31:0] element
        .m_axis_tuser  (m_axis_tuser),   // [1:0] status
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #5000000;
        $display("FAILED: results differ");
        $finish;
    end

    task automatic add_result(input logic [31:0] elem, input deq_pkg::status_t st,
                              input logic lst);
        deq_result_t r;
        r.element = elem;
        r.status  = st;
        r.last    = lst;
        pending_results.push_back(r);
        if (st == deq_pkg::STAT_FULL)
            n_full++;
        if (st == deq_pkg::STAT_EMPTY)
            n_empty++;
    endtask

    // apply one accepted item to the mirror and queue what it should produce
    task automatic deque_apply(input logic [2:0] act, input logic [31:0] val);
        int i;
        case (act)
            deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_BACK:
            begin
                if (fill_cnt >= DEPTH)
                    add_result('0, deq_pkg::STAT_FULL, 1'b1);
                else
                begin
                    if (act == deq_pkg::ACT_PUSH_FRONT)
                    begin
                        front_idx = (front_idx + DEPTH - 1) % DEPTH;
                        ring[front_idx] = val;
                    end
                    else
                        ring[(front_idx + fill_cnt) % DEPTH] = val;
                    fill_cnt++;
                    add_result('0, deq_pkg::STAT_OK, 1'b1);
                end
            end
            deq_pkg::ACT_POP_FRONT, deq_pkg::ACT_POP_BACK:
            begin
                if (fill_cnt == 0)
                    add_result('0, deq_pkg::STAT_EMPTY, 1'b1);
                else if (act == deq_pkg::ACT_POP_FRONT)
                begin
                    add_result(ring[front_idx], deq_pkg::STAT_OK, 1'b1);
                    front_idx = (front_idx + 1) % DEPTH;
                    fill_cnt--;
                end
                else
                begin
                    add_result(ring[(front_idx + fill_cnt - 1) % DEPTH],
                               deq_pkg::STAT_OK, 1'b1);
                    fill_cnt--;
                end
            end
            deq_pkg::ACT_LIST:
            begin
                n_lists++;
                if (fill_cnt == 0)
                    add_result('0, deq_pkg::STAT_EMPTY, 1'b1);
                else
                    for (i = 0; i < fill_cnt; i++)
                        add_result(ring[(front_idx + i) % DEPTH], deq_pkg::STAT_OK,
                                   (i == fill_cnt - 1));
            end
            default: ;  // codes 5..7 are dropped silently
        endcase
    endtask

    task automatic offer_action(input logic [2:0] act, input logic [31:0] val);
        int gap;
        gap = 0;
        while (gap < 60 && $urandom_range(99) < send_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, val, act};
        do
            @(posedge clk);
        while (!s_axis_tready);
        n_items++;
        deque_apply(act, val);
    endtask

    // stop offering, then wait for every expected result
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        deq_result_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_results++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 20)
                    $display("%0t: unexpected result elem=%h status=%0d last=%0b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            else
            begin
                e = pending_results.pop_front();
                if (m_axis_tdata !== e.element || m_axis_tuser !== e.status
                    || m_axis_tlast !== e.last)
                begin
                    mismatches++;
                    if (mismatches <= 20)
                        $display({"%0t: expected elem=%h status=%0d last=%0b, ",
                                  "got elem=%h status=%0d last=%0b"},
                                 $time, e.element, e.status, e.last,
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
            end
        end
    end

    // extremes, empty cases, ignored codes
    task automatic test_directed();
        offer_action(deq_pkg::ACT_LIST, 32'h0);
        offer_action(deq_pkg::ACT_POP_FRONT, 32'hffff_ffff);
        offer_action(deq_pkg::ACT_POP_BACK, 32'h0);
        offer_action(deq_pkg::ACT_PUSH_FRONT, 32'h7fff_ffff);
        offer_action(deq_pkg::ACT_PUSH_BACK, 32'h8000_0000);
        offer_action(deq_pkg::ACT_PUSH_FRONT, 32'h0000_0000);
        offer_action(deq_pkg::ACT_PUSH_BACK, 32'hffff_ffff);
        offer_action(deq_pkg::ACT_LIST, 32'h1234_5678);
        offer_action(3'd5, $urandom);
        offer_action(3'd6, $urandom);
        offer_action(3'd7, 32'hffff_ffff);
        offer_action(deq_pkg::ACT_POP_BACK, 32'h0);
        offer_action(deq_pkg::ACT_POP_FRONT, 32'h0);
        offer_action(deq_pkg::ACT_LIST, 32'h0);
        offer_action(deq_pkg::ACT_POP_FRONT, 32'h0);
        offer_action(deq_pkg::ACT_POP_BACK, 32'h0);
        offer_action(deq_pkg::ACT_LIST, 32'h0);
        offer_action(deq_pkg::ACT_POP_BACK, 32'h0);
    endtask

    // output held off while pushes keep coming: offers more pushes than the deque holds
    task automatic test_fill_under_backpressure();
        int i;
        drain_results();
        hold_left = 150;
        for (i = 0; i < 20; i++)
            offer_action($urandom_range(1) ? deq_pkg::ACT_PUSH_BACK
                                           : deq_pkg::ACT_PUSH_FRONT, pick_value());
        offer_action(deq_pkg::ACT_LIST, 32'h0);
        for (i = 0; i < 18; i++)
            offer_action($urandom_range(1) ? deq_pkg::ACT_POP_BACK
                                           : deq_pkg::ACT_POP_FRONT, 32'h0);
        drain_results();
    endtask

    // bursts with a drifting push/pop mix so the deque swings full and empty
    task automatic test_random(input int n, input int s_idle, input int r_stall);
        int i;
        int r;
        int push_pct;
        logic [2:0] act;
        send_idle_pct  = s_idle;
        recv_stall_pct = r_stall;
        push_pct = 50;
        for (i = 0; i < n; i++)
        begin
            if (i % 20 == 0)
                case ($urandom_range(2))
                    0: push_pct = 85;
                    1: push_pct = 50;
                    default: push_pct = 15;
                endcase
            r = $urandom_range(99);
            if (r < 3)
                act = 3'($urandom_range(7, 5));
            else if (r < 12)
                act = deq_pkg::ACT_LIST;
            else if ($urandom_range(99) < push_pct)
                act = $urandom_range(1) ? deq_pkg::ACT_PUSH_BACK : deq_pkg::ACT_PUSH_FRONT;
            else
                act = $urandom_range(1) ? deq_pkg::ACT_POP_BACK : deq_pkg::ACT_POP_FRONT;
            offer_action(act, pick_value());
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random(80, 0, 0);
        test_fill_under_backpressure();
        test_random(80, 84, 0);
        test_random(80, 0, 84);
        test_random(80, 22, 22);

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        drain_results();
        repeat (40) @(posedge clk);

        $display("Ran %0d items (%0d lists), checked %0d results", n_items, n_lists, n_results);
        $display("Full-drop results: %0d, empty results: %0d", n_full, n_empty);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/deq_pkg.sv
rtl/core/deq_cell.sv
rtl/core/double_ended_queue.sv
tb/tb_double_ended_queue.sv
